>>> hw/rtl/bdau_pkg.sv
// ----------------------------------------------------------------------------
// bdau_pkg
// Shared constants, types and state codes for the binary to decimal ascii
// unit.
// ----------------------------------------------------------------------------
package bdau_pkg;

	localparam int BIN_W   = 32;
	localparam int DIGITS  = 10;
	localparam int DIG_W   = 4;
	localparam int CNT_W   = $clog2(BIN_W);
	localparam int POS_W   = $clog2(DIGITS);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_NL    = 8'h0A;

	localparam logic [7:0] WB_ONE  = 8'd1;
	localparam logic [7:0] WB_TWO  = 8'd2;
	localparam logic [7:0] WB_FOUR = 8'd4;

	localparam logic REQ_UNSIGNED = 1'b0;
	localparam logic REQ_SIGNED   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_DIGIT,
		ST_NL
	} state_t;

	// per-cycle command shared by every digit cell
	typedef struct packed {
		logic clear;
		logic dabble;
		logic move;
	} cell_ctl_t;

endpackage

>>> hw/rtl/bdau_digit_cell.sv
// ----------------------------------------------------------------------------
// bdau_digit_cell
// One bcd digit of the shift-add-3 chain; also shifts its digit up the row
// during character output.
// ----------------------------------------------------------------------------
module bdau_digit_cell
	import bdau_pkg::*;
(
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic             bit_in,
	input  logic [DIG_W-1:0] digit_in,
	output logic [DIG_W-1:0] digit,
	output logic             bit_out
);

	logic [DIG_W-1:0] digit_q;
	logic [DIG_W-1:0] corr;

	// add 3 when the digit would overflow after doubling
	always_comb begin
		corr = (digit_q >= DIG_W'(5)) ? digit_q + DIG_W'(3) : digit_q;
	end

	assign bit_out = corr[DIG_W-1];
	assign digit   = digit_q;

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.dabble) begin
			digit_q <= {corr[DIG_W-2:0], bit_in};
		end else if (ctl.move) begin
			digit_q <= digit_in;
		end
	end

endmodule

>>> hw/rtl/binary_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// Converts one 32-bit number per transaction into ascii decimal text, one
// character per output transaction, most significant digit first.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | sink      | in_valid/in_stall  | req_type, value, width_bytes
//  out     | source    | out_valid/out_stall| text_char, last_char
//
//  an item is accepted, shifted bit by bit (shift-add-3) through ten digit cells
//  and scanned one digit position at a time (leading zeros dropped); a '-' comes
//  first for a negative signed number and a newline comes last for an unsigned one
//  a bad unsigned width is dropped in its accept cycle with no output
//  arst_n clears control state and output valid; cells clear per conversion
//  out_stall freezes the scan; the next transaction is accepted while the
//  final character still waits in the output register
//
module binary_to_decimal_ascii_unit
	import bdau_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             req_type,
	input  logic [BIN_W-1:0] value,
	input  logic [7:0]       width_bytes,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       text_char,
	output logic             last_char
);

	// control state
	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic               started_q, started_d;
	logic               out_valid_q;

	// payload state
	logic [BIN_W-1:0]   bin_q, bin_d;
	logic               signed_q, signed_d;
	logic               neg_q, neg_d;
	logic [7:0]         text_char_q;
	logic               last_char_q;

	// datapath signals
	logic               accept;
	logic               adv;
	logic               push;
	logic [7:0]         push_char;
	logic               push_last;
	logic               good;
	logic [BIN_W-1:0]   mag;
	cell_ctl_t          ctl;
	logic [DIG_W-1:0]   top_digit;

	// row of digit cells, index 0 holds the least significant digit
	logic [DIG_W-1:0]   digit [DIGITS];
	logic               carry [DIGITS];

	genvar gi;
	generate
		for (gi = 0; gi < DIGITS; gi++) begin : g_cell
			logic             bin_w;
			logic [DIG_W-1:0] din_w;
			if (gi == 0) begin : g_first
				assign bin_w = bin_q[BIN_W-1];
				assign din_w = '0;
			end else begin : g_rest
				assign bin_w = carry[gi-1];
				assign din_w = digit[gi-1];
			end
			bdau_digit_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.bit_in   (bin_w),
				.digit_in (din_w),
				.digit    (digit[gi]),
				.bit_out  (carry[gi])
			);
		end
	endgenerate

	assign top_digit = digit[DIGITS-1];

	// handshakes
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign adv      = !out_valid_q || !out_stall;

	// magnitude selection, two's complement negation covers the most
	// negative value since the result is read as unsigned
	always_comb begin
		good = 1'b1;
		mag  = value;
		if (req_type == REQ_SIGNED) begin
			mag = value[BIN_W-1] ? (~value) + BIN_W'(1) : value;
		end else begin
			case (width_bytes)
				WB_ONE:  mag = {{(BIN_W-8){1'b0}}, value[7:0]};
				WB_TWO:  mag = {{(BIN_W-16){1'b0}}, value[15:0]};
				WB_FOUR: mag = value;
				default: good = 1'b0;
			endcase
		end
	end

	// next state and outputs
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		pos_d     = pos_q;
		started_d = started_q;
		bin_d     = bin_q;
		signed_d  = signed_q;
		neg_d     = neg_q;
		ctl       = '0;
		push      = 1'b0;
		push_char = CHAR_ZERO;
		push_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && good) begin
					ctl.clear = 1'b1;
					bin_d     = mag;
					signed_d  = (req_type == REQ_SIGNED);
					neg_d     = (req_type == REQ_SIGNED) && value[BIN_W-1];
					cnt_d     = '0;
					state_d   = ST_CONV;
				end
			end
			ST_CONV: begin
				// one binary bit enters the row per cycle
				ctl.dabble = 1'b1;
				bin_d      = {bin_q[BIN_W-2:0], 1'b0};
				cnt_d      = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(BIN_W-1)) begin
					pos_d     = '0;
					started_d = 1'b0;
					state_d   = neg_q ? ST_SIGN : ST_DIGIT;
				end
			end
			ST_SIGN: begin
				if (adv) begin
					push      = 1'b1;
					push_char = CHAR_MINUS;
					state_d   = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (adv) begin
					// drop leading zeros, but always keep the units digit
					if (started_q || top_digit != '0 || pos_q == POS_W'(DIGITS-1)) begin
						push      = 1'b1;
						push_char = CHAR_ZERO + {{(8-DIG_W){1'b0}}, top_digit};
						push_last = signed_q && (pos_q == POS_W'(DIGITS-1));
						started_d = 1'b1;
					end
					ctl.move = 1'b1;
					pos_d    = pos_q + POS_W'(1);
					if (pos_q == POS_W'(DIGITS-1)) begin
						state_d = signed_q ? ST_IDLE : ST_NL;
					end
				end
			end
			ST_NL: begin
				if (adv) begin
					push      = 1'b1;
					push_char = CHAR_NL;
					push_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pos_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			pos_q       <= pos_d;
			started_q   <= started_d;
			out_valid_q <= push || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		bin_q    <= bin_d;
		signed_q <= signed_d;
		neg_q    <= neg_d;
		if (push) begin
			text_char_q <= push_char;
			last_char_q <= push_last;
		end
	end

	assign out_valid = out_valid_q;
	assign text_char = text_char_q;
	assign last_char = last_char_q;

endmodule
